// ===== sv/sfp_pkg.sv =====
// Package for the serial-bus frame parser: frame geometry, marker bytes,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
package sfp_pkg;

	localparam int LAST_INDEX = 24;
	localparam int BUF_DEPTH  = LAST_INDEX + 1;
	localparam int POS_W      = $clog2(BUF_DEPTH);
	localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
	localparam int CHAN_W     = 11;
	localparam int CHAN_COUNT = 8;
	localparam int CHAN_BYTES = (CHAN_W * CHAN_COUNT) / 8;
	localparam int OUT_W      = CHAN_W * CHAN_COUNT;

	localparam logic [7:0] SYNC_MARK = 8'h0F;
	localparam logic [7:0] END_MARK  = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic fill_inc;
		logic fill_clr;
		logic fill_full;
		logic shift_en;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic at_last;
		logic byte_sync;
		logic byte_end;
		logic next_sync;
		logic last_shift;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== sv/sbus_frame_parser.sv =====
// Serial-bus frame parser, eight 11-bit channels. m_tvalid rises after the end byte of a good
// frame is taken and the controller has passed through its emit state, later while an earlier
// result is still waiting. Throughput: one byte per cycle while filling; a good end byte holds
// the input off while in the emit state, until the output register is free; after a bad end
// byte, a resync shifts the buffer one place a cycle, with the input held off meanwhile.
// Reset clears the controller, fill count and output valid; the frame buffer is not cleared.
module sbus_frame_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [sfp_pkg::OUT_W-1:0]  m_tdata   // chan_one .. chan_eight, 11 bits each
);

	sfp_pkg::dp_cmd_t  cmd;
	sfp_pkg::dp_stat_t stat;

	sfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// ===== sv/sfp_datapath.sv =====
// Datapath of the serial-bus frame parser: frame buffer, fill counter and output register.
// Driven by the command struct from sfp_ctrl; depends on sfp_pkg.
module sfp_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    rx_byte,
	input  sfp_pkg::dp_cmd_t              cmd,
	output sfp_pkg::dp_stat_t             stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sfp_pkg::OUT_W-1:0]     out_data
);

	logic [7:0]                     buf_q [sfp_pkg::BUF_DEPTH];
	logic [sfp_pkg::FILL_W-1:0]     fill_q;
	logic                           out_valid_q;
	logic [sfp_pkg::OUT_W-1:0]      out_data_q;
	logic [sfp_pkg::POS_W-1:0]      wr_idx;
	logic [sfp_pkg::OUT_W-1:0]      frame_bits;

	assign wr_idx = fill_q[sfp_pkg::POS_W-1:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < sfp_pkg::BUF_DEPTH; i++) begin
			if (cmd.shift_en) begin
				if (i < sfp_pkg::LAST_INDEX) begin
					buf_q[i] <= buf_q[i+1];
				end
			end else if (cmd.wr_en && wr_idx == sfp_pkg::POS_W'(i)) begin
				buf_q[i] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (cmd.fill_full) begin
			fill_q <= sfp_pkg::FILL_W'(sfp_pkg::BUF_DEPTH);
		end else if (cmd.fill_inc) begin
			fill_q <= fill_q + 1'b1;
		end else if (cmd.shift_en) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	always_comb begin
		for (int k = 0; k < sfp_pkg::CHAN_BYTES; k++) begin
			frame_bits[8*k +: 8] = buf_q[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= frame_bits;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign stat.fill_zero  = (fill_q == '0);
	assign stat.at_last    = (fill_q == sfp_pkg::FILL_W'(sfp_pkg::LAST_INDEX));
	assign stat.byte_sync  = (rx_byte == sfp_pkg::SYNC_MARK);
	assign stat.byte_end   = (rx_byte == sfp_pkg::END_MARK);
	assign stat.next_sync  = (buf_q[1] == sfp_pkg::SYNC_MARK);
	assign stat.last_shift = (fill_q == sfp_pkg::FILL_W'(1));
	assign stat.out_free   = !out_valid_q || out_ready;

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_en |-> fill_q != '0)
		else $error("Buffer shifted while empty.");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sfp_pkg::FILL_W'(sfp_pkg::BUF_DEPTH))
		else $error("Fill count out of range.");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q && fill_q == '0)
		else $error("Frame load did not present a result and empty the buffer.");

endmodule

// ===== sv/sfp_ctrl.sv =====
// Controller of the serial-bus frame parser: sync hunt, frame fill, emit and resync shift.
// Issues commands to sfp_datapath; depends on sfp_pkg.
module sfp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfp_pkg::dp_stat_t   stat,
	output sfp_pkg::dp_cmd_t    cmd
);

	sfp_pkg::state_t state_q;
	sfp_pkg::state_t state_d;
	logic            accept;

	assign in_ready = (state_q == sfp_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfp_pkg::ST_IDLE: begin
				if (accept && !(stat.fill_zero && !stat.byte_sync) && stat.at_last) begin
					state_d = stat.byte_end ? sfp_pkg::ST_EMIT : sfp_pkg::ST_SHIFT;
				end
			end
			sfp_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					state_d = sfp_pkg::ST_IDLE;
				end
			end
			sfp_pkg::ST_SHIFT: begin
				if (stat.last_shift || stat.next_sync) begin
					state_d = sfp_pkg::ST_IDLE;
				end
			end
			default: state_d = sfp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			sfp_pkg::ST_IDLE: begin
				if (accept && !(stat.fill_zero && !stat.byte_sync)) begin
					cmd.wr_en = 1'b1;
					if (!stat.at_last) begin
						cmd.fill_inc = 1'b1;
					end else if (!stat.byte_end) begin
						cmd.fill_full = 1'b1;
					end
				end
			end
			sfp_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.fill_clr = 1'b1;
				end
			end
			sfp_pkg::ST_SHIFT: begin
				cmd.shift_en = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> state_q == sfp_pkg::ST_IDLE)
		else $error("Buffer written outside the idle state.");

	a_emit_return: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == sfp_pkg::ST_IDLE)
		else $error("Controller did not return to idle after emitting a frame.");

	a_shift_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_full |=> state_q == sfp_pkg::ST_SHIFT)
		else $error("Bad end byte did not start a resync shift.");

endmodule

// ===== verif/tb_sbus_frame_parser.sv =====
// Self-checking testbench for sbus_frame_parser: streams received bytes, predicts the decoded
// channel items with a scoreboard class and checks every result item field by field.
// Depends on sfp_pkg and the sbus_frame_parser RTL.
module tb_sbus_frame_parser;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_BYTES  = 270;

	typedef enum {FILL_CLEAN, FILL_ZEROS, FILL_ONES, FILL_MIXED} fill_kind_t;

	class frame_scoreboard;
		logic [7:0] frame_buf [sfp_pkg::BUF_DEPTH];
		int unsigned fill_pos;
		logic [sfp_pkg::OUT_W-1:0] pending_frames [$];
		int errors;
		string chan_names [sfp_pkg::CHAN_COUNT] = '{"chan_one", "chan_two", "chan_three",
			"chan_four", "chan_five", "chan_six", "chan_seven", "chan_eight"};

		function new();
			fill_pos = 0;
			errors = 0;
			foreach (frame_buf[i]) frame_buf[i] = 8'h00;
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		// Returns 1 when the byte was stored, 0 when it was dropped while hunting for sync.
		function bit note_byte(input logic [7:0] b);
			int sync_at;
			logic [sfp_pkg::OUT_W-1:0] chans;
			if (fill_pos == 0 && b != sfp_pkg::SYNC_MARK)
				return 1'b0;
			frame_buf[fill_pos] = b;
			if (fill_pos != sfp_pkg::LAST_INDEX) begin
				fill_pos++;
				return 1'b1;
			end
			if (b == sfp_pkg::END_MARK) begin
				// The channels are the bit stream of bytes 1 to 11, byte 1 lowest.
				for (int k = 0; k < sfp_pkg::CHAN_BYTES; k++)
					chans[8*k +: 8] = frame_buf[k+1];
				pending_frames.push_back(chans);
				fill_pos = 0;
				return 1'b1;
			end
			sync_at = 0;
			for (int i = 1; i <= sfp_pkg::LAST_INDEX; i++) begin
				if (frame_buf[i] == sfp_pkg::SYNC_MARK) begin
					sync_at = i;
					break;
				end
			end
			if (sync_at != 0) begin
				for (int i = 0; i <= sfp_pkg::LAST_INDEX - sync_at; i++)
					frame_buf[i] = frame_buf[i+sync_at];
				fill_pos = sfp_pkg::LAST_INDEX - sync_at + 1;
			end else begin
				fill_pos = 0;
			end
			return 1'b1;
		endfunction

		task check_result(input logic [sfp_pkg::OUT_W-1:0] got);
			logic [sfp_pkg::OUT_W-1:0] want;
			if (pending_frames.size() == 0) begin
				report_mismatch($sformatf("result item %h with no frame pending", got));
				return;
			end
			want = pending_frames.pop_front();
			for (int k = 0; k < sfp_pkg::CHAN_COUNT; k++) begin
				if (got[sfp_pkg::CHAN_W*k +: sfp_pkg::CHAN_W] !==
						want[sfp_pkg::CHAN_W*k +: sfp_pkg::CHAN_W])
					report_mismatch($sformatf("%s: got %0d, expected %0d", chan_names[k],
						got[sfp_pkg::CHAN_W*k +: sfp_pkg::CHAN_W],
						want[sfp_pkg::CHAN_W*k +: sfp_pkg::CHAN_W]));
			end
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [7:0]                s_tdata = 8'h00;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [sfp_pkg::OUT_W-1:0] m_tdata;

	frame_scoreboard sb = new();
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int stored_bytes = 0;
	int cycles = 0;

	sbus_frame_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (sb.note_byte(b))
			stored_bytes++;
	endtask

	function automatic logic [7:0] data_byte(input fill_kind_t kind);
		logic [7:0] b;
		case (kind)
			FILL_ZEROS: b = 8'h00;
			FILL_ONES:  b = 8'hFF;
			FILL_MIXED: begin
				case ($urandom_range(7))
					0:       b = sfp_pkg::SYNC_MARK;
					1:       b = sfp_pkg::END_MARK;
					default: b = 8'($urandom_range(255));
				endcase
			end
			default: begin
				do
					b = 8'($urandom_range(255));
				while (b == sfp_pkg::SYNC_MARK);
			end
		endcase
		return b;
	endfunction

	// A sync byte, 23 body bytes with an optional extra sync byte, then the given end byte.
	task automatic send_frame(input logic [7:0] end_byte, input fill_kind_t kind,
			input int sync_pos);
		put_byte(sfp_pkg::SYNC_MARK);
		for (int p = 1; p < sfp_pkg::LAST_INDEX; p++)
			put_byte((p == sync_pos) ? sfp_pkg::SYNC_MARK : data_byte(kind));
		put_byte(end_byte);
	endtask

	initial begin
		int idle_src [4];
		int idle_snk [4];
		int target;
		logic [7:0] end_byte;
		idle_src = '{0, 66, 0, 16};
		idle_snk = '{0, 0, 66, 16};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hA5);
		send_frame(sfp_pkg::END_MARK, FILL_ONES, 0);
		send_frame(sfp_pkg::END_MARK, FILL_ZEROS, 0);
		send_frame(8'hFF, FILL_CLEAN, 0);
		put_byte(8'h55);
		send_frame(8'h80, FILL_CLEAN, 1);
		put_byte(sfp_pkg::END_MARK);
		send_frame(sfp_pkg::SYNC_MARK, FILL_CLEAN, 0);
		for (int p = 1; p < sfp_pkg::LAST_INDEX; p++)
			put_byte(data_byte(FILL_CLEAN));
		put_byte(sfp_pkg::END_MARK);
		send_frame(8'h01, FILL_ZEROS, 12);
		send_frame(sfp_pkg::END_MARK, FILL_MIXED, 0);

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = idle_src[ph];
			snk_stall_pct = idle_snk[ph];
			target = stored_bytes + PHASE_BYTES;
			while (stored_bytes < target) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
						send_frame(sfp_pkg::END_MARK,
							$urandom_range(1) ? FILL_CLEAN : FILL_MIXED,
							($urandom_range(3) == 0) ? $urandom_range(1, 23) : 0);
					11, 12, 13, 14, 15, 16: begin
						end_byte = ($urandom_range(4) == 0) ? sfp_pkg::SYNC_MARK :
							8'($urandom_range(1, 255));
						send_frame(end_byte, $urandom_range(1) ? FILL_CLEAN : FILL_MIXED,
							$urandom_range(23));
					end
					default: begin
						repeat ($urandom_range(1, 6))
							put_byte(8'($urandom_range(255)));
					end
				endcase
			end
		end
		s_tvalid <= 1'b0;

		while (sb.pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
